// ===== src/spi_master_shifter_defines.svh =====
// Assertion macros for the SPI master shifter.
`ifndef SPI_MASTER_SHIFTER_DEFINES_SVH
`define SPI_MASTER_SHIFTER_DEFINES_SVH

// Check that cons holds in the same cycle as ante
`define SPIMS_ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spi_master_shifter: check failed");

// Check that cons holds in the cycle after ante
`define SPIMS_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spi_master_shifter: check failed");

`endif

// ===== src/spims_pkg.sv =====
`default_nettype none

package spims_pkg;

    // Transmit buffer depth and derived widths
    localparam int MAX_BYTES = 8;
    localparam int BUF_IDX_W = $clog2(MAX_BYTES);
    localparam int PTR_W     = $clog2(MAX_BYTES + 1);
    localparam int CNT_W     = 4;
    localparam int LINE_W    = 4;
    localparam int HP_W      = 8;
    localparam int MODE_W    = 2;
    localparam int BIT_IDX_W = 3;

    // Port widths
    localparam int IN_DATA_W  = 24;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 24;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    // Item kinds carried in tuser
    typedef enum logic [IN_USER_W-1:0] {
        KIND_TICK  = 2'd0,
        KIND_PUSH  = 2'd1,
        KIND_START = 2'd2
    } kind_t;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SPI_MODE    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 1'b1;

    // Input word, last field in the lowest bits
    typedef struct packed {
        logic [6:0]        pad;
        logic              miso;
        logic [LINE_W-1:0] select_id;
        logic [CNT_W-1:0]  byte_count;
        logic [7:0]        tx_byte;
    } in_word_t;

    // Result word, last field in the lowest bits
    typedef struct packed {
        logic [5:0]        pad;
        logic              error;
        logic              busy_res;
        logic              rx_valid;
        logic [7:0]        rx_byte;
        logic [LINE_W-1:0] cs_line;
        logic              cs_active;
        logic              mosi;
        logic              sclk;
    } out_word_t;

endpackage

`default_nettype wire

// ===== src/spi_master_shifter.sv =====
// Channel   Direction  Accept when                    Payload
// s_axis    in         s_axis_tvalid & s_axis_tready  tdata: tx_byte, byte_count, select_id,
//                                                     miso; tuser: kind
// m_axis    out        m_axis_tvalid & m_axis_tready  tdata: pin levels, rx byte, status;
//                                                     tlast: rx_last
// cfg       in         cfg_we                         cfg_index, cfg_data
//
// The transfer state is updated in one pass between the state registers and the result
// register, so a word is accepted on every cycle unless m_axis stalls the result register.
// One result word per input word, in the result register from the cycle after acceptance.
// s_axis_tready drops only while the result register holds a word that m_axis stalls.
// rst_n clears all control state; the transmit buffer is not cleared.
`default_nettype none

`include "spi_master_shifter_defines.svh"

module spi_master_shifter
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [7:0] tx_byte, [11:8] byte_count, [15:12] select_id, [16] miso, [23:17] zero
    input  wire logic [spims_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // [1:0] kind
    input  wire logic [spims_pkg::IN_USER_W-1:0]   s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // [0] sclk, [1] mosi, [2] cs_active, [6:3] cs_line, [14:7] rx_byte,
    // [15] rx_valid, [16] busy_res, [17] error, [23:18] zero
    output logic [spims_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
    output logic                                   m_axis_tlast,
    input  wire logic                              cfg_we,
    input  wire logic [spims_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [spims_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int MAXB = spims_pkg::MAX_BYTES;
    localparam int IW   = spims_pkg::BUF_IDX_W;
    localparam int PW   = spims_pkg::PTR_W;
    localparam int CW   = spims_pkg::CNT_W;
    localparam int LW   = spims_pkg::LINE_W;
    localparam int HW   = spims_pkg::HP_W;
    localparam int BW   = spims_pkg::BIT_IDX_W;

    spims_pkg::in_word_t  in_word;
    spims_pkg::out_word_t out_word;
    spims_pkg::out_word_t out_reg;
    spims_pkg::out_word_t m_word;

    logic           s_fire;
    logic           out_valid_reg;
    logic           out_last_reg;

    // Transfer state
    logic [7:0]     tx_buf_reg [MAXB];
    logic [PW-1:0]  load_ptr_reg,    load_ptr_next;
    logic [7:0]     rx_shift_reg,    rx_shift_next;
    logic [CW-1:0]  byte_idx_reg,    byte_idx_next;
    logic [BW-1:0]  bit_idx_reg,     bit_idx_next;
    logic           half_phase_reg,  half_phase_next;
    logic [HW-1:0]  tick_cnt_reg,    tick_cnt_next;
    logic [CW-1:0]  total_bytes_reg, total_bytes_next;
    logic [LW-1:0]  active_line_reg, active_line_next;
    logic           running_reg,     running_next;
    logic           clock_reg,       clock_next;
    logic           data_reg;
    logic [spims_pkg::MODE_W-1:0] spi_mode_reg;
    logic [HW-1:0]  half_period_reg;

    // Per-word decode
    logic           cpol;
    logic           cpha;
    logic [HW-1:0]  hp_eff;
    logic [HW:0]    tick_sum;
    logic           buf_we;
    logic           rx_valid;
    logic           rx_last;
    logic [7:0]     rx_byte;
    logic           error;
    logic [CW-1:0]  byte_adv;
    logic           begin_bit;
    logic [CW-1:0]  bb_byte;
    logic [BW-1:0]  bb_bit;
    logic           run_span_ok;

    assign in_word       = spims_pkg::in_word_t'(s_axis_tdata);
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign cpol          = spi_mode_reg[1];
    assign cpha          = spi_mode_reg[0];
    assign hp_eff        = (half_period_reg == '0) ? HW'(1) : half_period_reg;
    assign tick_sum      = {1'b0, tick_cnt_reg} + (HW+1)'(1);
    assign byte_adv      = byte_idx_reg + CW'(1);

    // Next transfer state for the word at the input
    always_comb
    begin
        load_ptr_next    = load_ptr_reg;
        rx_shift_next    = rx_shift_reg;
        byte_idx_next    = byte_idx_reg;
        bit_idx_next     = bit_idx_reg;
        half_phase_next  = half_phase_reg;
        tick_cnt_next    = tick_cnt_reg;
        total_bytes_next = total_bytes_reg;
        active_line_next = active_line_reg;
        running_next     = running_reg;
        clock_next       = clock_reg;
        buf_we           = 1'b0;
        rx_valid         = 1'b0;
        rx_last          = 1'b0;
        rx_byte          = '0;
        error            = 1'b0;
        begin_bit        = 1'b0;
        bb_byte          = '0;
        bb_bit           = '0;

        case (s_axis_tuser)
            spims_pkg::KIND_PUSH:
            begin
                if (running_reg || load_ptr_reg >= PW'(MAXB))
                begin
                    error = 1'b1;
                end
                else
                begin
                    buf_we        = 1'b1;
                    load_ptr_next = load_ptr_reg + PW'(1);
                end
            end
            spims_pkg::KIND_START:
            begin
                if (running_reg || {1'b0, in_word.byte_count} > (CW+1)'(MAXB))
                begin
                    error = 1'b1;
                end
                else
                begin
                    load_ptr_next = '0;
                    if (in_word.byte_count != '0)
                    begin
                        running_next     = 1'b1;
                        total_bytes_next = in_word.byte_count;
                        active_line_next = in_word.select_id;
                        byte_idx_next    = '0;
                        bit_idx_next     = '0;
                        half_phase_next  = 1'b0;
                        tick_cnt_next    = '0;
                        rx_shift_next    = '0;
                        clock_next       = cpol;
                        begin_bit        = 1'b1;
                    end
                end
            end
            spims_pkg::KIND_TICK:
            begin
                if (running_reg)
                begin
                    tick_cnt_next = tick_sum[HW-1:0];
                    if (tick_sum >= {1'b0, hp_eff})
                    begin
                        tick_cnt_next = '0;
                        if (!half_phase_reg)
                        begin
                            // End of first half: sample MISO
                            clock_next    = cpha ? cpol : !cpol;
                            rx_shift_next = {rx_shift_reg[6:0], in_word.miso};
                            if (bit_idx_reg == BW'(7))
                            begin
                                rx_valid = 1'b1;
                                rx_byte  = rx_shift_next;
                                rx_last  = (byte_adv == total_bytes_reg);
                            end
                            half_phase_next = 1'b1;
                        end
                        else
                        begin
                            // End of second half: advance to the next bit or finish
                            half_phase_next = 1'b0;
                            if (!cpha)
                            begin
                                clock_next = cpol;
                            end
                            bit_idx_next = bit_idx_reg + BW'(1);
                            if (bit_idx_reg == BW'(7))
                            begin
                                byte_idx_next = byte_adv;
                            end
                            if (byte_idx_next >= total_bytes_reg)
                            begin
                                running_next     = 1'b0;
                                active_line_next = '0;
                                byte_idx_next    = '0;
                                bit_idx_next     = '0;
                                clock_next       = cpol;
                            end
                            else
                            begin
                                begin_bit = 1'b1;
                            end
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase

        bb_byte = byte_idx_next;
        bb_bit  = bit_idx_next;
        if (begin_bit && cpha)
        begin
            clock_next = !cpol;
        end
        if (!running_next)
        begin
            clock_next = cpol;
        end
    end

    // Assemble the result word; MOSI comes from data_reg, which loads with it
    always_comb
    begin
        out_word           = '0;
        out_word.sclk      = clock_next;
        out_word.cs_active = running_next && (active_line_next != '0);
        out_word.cs_line   = active_line_next;
        out_word.rx_byte   = rx_byte;
        out_word.rx_valid  = rx_valid;
        out_word.busy_res  = running_next;
        out_word.error     = error;
    end

    // Write the transmit buffer
    always_ff @(posedge clk)
    begin
        if (s_fire && buf_we)
        begin
            tx_buf_reg[load_ptr_reg[IW-1:0]] <= in_word.tx_byte;
        end
    end

    // Hold transfer state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_ptr_reg    <= '0;
            rx_shift_reg    <= '0;
            byte_idx_reg    <= '0;
            bit_idx_reg     <= '0;
            half_phase_reg  <= 1'b0;
            tick_cnt_reg    <= '0;
            total_bytes_reg <= '0;
            active_line_reg <= '0;
            running_reg     <= 1'b0;
            clock_reg       <= 1'b0;
            data_reg        <= 1'b0;
            spi_mode_reg    <= '0;
            half_period_reg <= HW'(1);
        end
        else
        begin
            if (s_fire)
            begin
                load_ptr_reg    <= load_ptr_next;
                rx_shift_reg    <= rx_shift_next;
                byte_idx_reg    <= byte_idx_next;
                bit_idx_reg     <= bit_idx_next;
                half_phase_reg  <= half_phase_next;
                tick_cnt_reg    <= tick_cnt_next;
                total_bytes_reg <= total_bytes_next;
                active_line_reg <= active_line_next;
                running_reg     <= running_next;
                clock_reg       <= clock_next;
                // Drive MOSI from the buffer entry of the bit that begins
                if (begin_bit)
                begin
                    data_reg <= tx_buf_reg[bb_byte[IW-1:0]][BW'(7) - bb_bit];
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    spims_pkg::CFG_SPI_MODE:
                    begin
                        if (!running_reg)
                        begin
                            spi_mode_reg <= cfg_data[spims_pkg::MODE_W-1:0];
                        end
                    end
                    spims_pkg::CFG_HALF_PERIOD:
                    begin
                        half_period_reg <= cfg_data[HW-1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Result register: load on accept, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            out_reg      <= out_word;
            out_last_reg <= rx_last;
        end
    end

    // Merge the MOSI level into the held result word
    always_comb
    begin
        m_word      = out_reg;
        m_word.mosi = data_reg;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = m_word;
    assign m_axis_tlast  = out_last_reg;

    // Checks
    assign run_span_ok = (total_bytes_reg != '0) && (byte_idx_reg < total_bytes_reg);

    `SPIMS_ASSERT_SAME(idle_no_line, !running_reg, active_line_reg == '0)
    `SPIMS_ASSERT_SAME(run_in_range, running_reg, run_span_ok)
    `SPIMS_ASSERT_NEXT(accept_gives_result, s_fire, m_axis_tvalid)
    `SPIMS_ASSERT_SAME(last_needs_rx, m_axis_tvalid && m_axis_tlast, out_reg.rx_valid)

endmodule

`default_nettype wire

// ===== dv/spi_master_shifter_tb.sv =====
`timescale 1ns / 100ps

module spi_master_shifter_tb;

    // Kind code outside the enum: the block must ignore it
    localparam logic [spims_pkg::IN_USER_W-1:0] KIND_UNUSED = 2'd3;

    // Expected result word plus its tlast bit
    typedef struct packed {
        spims_pkg::out_word_t word;
        logic                 last;
    } pin_result_t;

    // One row of the directed stimulus table
    typedef struct packed {
        logic [spims_pkg::IN_USER_W-1:0] kind;
        logic [7:0]                      txb;
        logic [spims_pkg::CNT_W-1:0]     cnt;
        logic [spims_pkg::LINE_W-1:0]    sel;
        logic                            miso;
        logic                            typed;
        logic                            err;
    } stim_row_t;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [spims_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [spims_pkg::IN_USER_W-1:0]  s_axis_tuser = '0;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [spims_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic                             m_axis_tlast;
    logic                             cfg_we = 1'b0;
    logic [spims_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [spims_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // Shadow of the block's transfer state, reset values
    logic [7:0]                   tx_mem [spims_pkg::MAX_BYTES];
    logic [spims_pkg::PTR_W-1:0]  ld_ptr = '0;
    logic [7:0]                   rx_sh = '0;
    logic [3:0]                   byte_idx = '0;
    logic [2:0]                   bit_idx = '0;
    logic                         half_ph = 1'b0;
    logic [7:0]                   tick_cnt = '0;
    logic [spims_pkg::CNT_W-1:0]  total = '0;
    logic [spims_pkg::LINE_W-1:0] line = '0;
    logic                         run = 1'b0;
    logic                         clk_lvl = 1'b0;
    logic                         data_lvl = 1'b0;
    logic [spims_pkg::MODE_W-1:0] mode_reg = '0;
    logic [spims_pkg::HP_W-1:0]   half_reg = 8'd1;

    pin_result_t pin_words_q [$];
    int          mismatches = 0;
    int          items_sent = 0;
    logic        calm = 1'b0;

    spi_master_shifter u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    // Load the current bit of the current byte onto MOSI; with CPHA set, also drive SCLK active
    function automatic void drive_bit();
        logic [7:0] b;
        b = tx_mem[byte_idx[spims_pkg::BUF_IDX_W-1:0]];
        if (mode_reg[0])
            clk_lvl = ~mode_reg[1];
        data_lvl = b[3'd7 - bit_idx];
    endfunction

    // Advance the shadow state by one word and return the pin levels after it
    function automatic pin_result_t shift_predict(logic [spims_pkg::IN_USER_W-1:0] kind,
                                                  spims_pkg::in_word_t w);
        pin_result_t r;
        logic [7:0]  hp_eff;
        r = '0;
        case (kind)
            spims_pkg::KIND_PUSH:
            begin
                if (run || ld_ptr >= spims_pkg::MAX_BYTES)
                    r.word.error = 1'b1;
                else
                begin
                    tx_mem[ld_ptr[spims_pkg::BUF_IDX_W-1:0]] = w.tx_byte;
                    ld_ptr = ld_ptr + 1'b1;
                end
            end
            spims_pkg::KIND_START:
            begin
                if (run || w.byte_count > spims_pkg::MAX_BYTES)
                    r.word.error = 1'b1;
                else
                begin
                    ld_ptr = '0;
                    if (w.byte_count != 0)
                    begin
                        run      = 1'b1;
                        total    = w.byte_count;
                        line     = w.select_id;
                        byte_idx = '0;
                        bit_idx  = '0;
                        half_ph  = 1'b0;
                        tick_cnt = '0;
                        rx_sh    = '0;
                        clk_lvl  = mode_reg[1];
                        drive_bit();
                    end
                end
            end
            spims_pkg::KIND_TICK:
            begin
                if (run)
                begin
                    hp_eff   = (half_reg == 0) ? 8'd1 : half_reg;
                    tick_cnt = tick_cnt + 1'b1;
                    if (tick_cnt >= hp_eff)
                    begin
                        tick_cnt = '0;
                        if (!half_ph)
                        begin
                            // first half ends: sampling edge
                            clk_lvl = mode_reg[0] ? mode_reg[1] : ~mode_reg[1];
                            rx_sh   = {rx_sh[6:0], w.miso};
                            if (bit_idx == 3'd7)
                            begin
                                r.word.rx_valid = 1'b1;
                                r.word.rx_byte  = rx_sh;
                                r.last          = (4'(byte_idx + 1'b1) == total);
                            end
                            half_ph = 1'b1;
                        end
                        else
                        begin
                            // second half ends: step to the next bit or finish
                            half_ph = 1'b0;
                            if (!mode_reg[0])
                                clk_lvl = mode_reg[1];
                            if (bit_idx == 3'd7)
                            begin
                                bit_idx  = '0;
                                byte_idx = byte_idx + 1'b1;
                            end
                            else
                                bit_idx = bit_idx + 1'b1;
                            if (byte_idx >= total)
                            begin
                                run      = 1'b0;
                                line     = '0;
                                byte_idx = '0;
                                bit_idx  = '0;
                                clk_lvl  = mode_reg[1];
                            end
                            else
                                drive_bit();
                        end
                    end
                end
            end
            default: ;
        endcase
        if (!run)
            clk_lvl = mode_reg[1];
        r.word.sclk      = clk_lvl;
        r.word.mosi      = data_lvl;
        r.word.cs_active = run && (line != 0);
        r.word.cs_line   = line;
        r.word.busy_res  = run;
        return r;
    endfunction

    // Offer one word, hold it until accepted, then record its expected result
    task automatic send_item(logic [spims_pkg::IN_USER_W-1:0] kind, spims_pkg::in_word_t w,
                             logic typed = 1'b0, logic typed_err = 1'b0);
        pin_result_t r;
        while (!calm && $urandom_range(99) < 17)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        s_axis_tuser  <= kind;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        r = shift_predict(kind, w);
        if (typed)
        begin
            r = '0;
            r.word.error = typed_err;
        end
        pin_words_q.push_back(r);
        items_sent++;
    endtask

    function automatic spims_pkg::in_word_t rand_word();
        spims_pkg::in_word_t w;
        w            = '0;
        w.tx_byte    = 8'($urandom_range(255));
        w.byte_count = 4'($urandom_range(15));
        w.select_id  = 4'($urandom_range(15));
        w.miso       = 1'($urandom_range(1));
        return w;
    endfunction

    // Any kind, any fields
    task automatic send_noise();
        send_item(2'($urandom_range(3)), rand_word());
    endtask

    // Write one register and mirror it in the shadow
    task automatic write_cfg(logic [spims_pkg::CFG_IDX_W-1:0] idx,
                             logic [spims_pkg::CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        if (idx == spims_pkg::CFG_SPI_MODE)
        begin
            if (!run)
                mode_reg = val[spims_pkg::MODE_W-1:0];
        end
        else
            half_reg = val;
    endtask

    // Hold the sender until every result has come back, then let the block settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pin_words_q.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // Byte count for a start, mostly short transfers, sometimes above the buffer depth
    function automatic logic [spims_pkg::CNT_W-1:0] pick_count();
        int p;
        p = $urandom_range(99);
        if (p < 60)
            return 4'd1;
        else if (p < 85)
            return 4'($urandom_range(2, 3));
        else if (p < 95)
            return 4'($urandom_range(4, spims_pkg::MAX_BYTES));
        return 4'($urandom_range(spims_pkg::MAX_BYTES + 1, 15));
    endfunction

    // One configuration phase: settle, write both registers, then send at least len words
    task automatic run_phase(logic [spims_pkg::MODE_W-1:0] mode,
                             logic [spims_pkg::HP_W-1:0] hp, int len, logic quiet);
        int                  n;
        int                  k;
        int                  p;
        spims_pkg::in_word_t w;
        drain();
        write_cfg(spims_pkg::CFG_SPI_MODE, spims_pkg::CFG_DATA_W'(mode));
        write_cfg(spims_pkg::CFG_HALF_PERIOD, hp);
        cfg_we <= 1'b0;
        calm = quiet;
        n = 0;
        while (n < len)
        begin
            if (run)
            begin
                // mostly clock the transfer along, sometimes poke it while busy
                if ($urandom_range(99) < 85)
                begin
                    w      = '0;
                    w.miso = 1'($urandom_range(1));
                    send_item(spims_pkg::KIND_TICK, w);
                end
                else
                    send_noise();
                n++;
            end
            else
            begin
                p = $urandom_range(99);
                if (p < 55)
                begin
                    // fill the buffer, then launch
                    k = $urandom_range(1, spims_pkg::MAX_BYTES);
                    repeat (k)
                        send_item(spims_pkg::KIND_PUSH, rand_word());
                    w            = rand_word();
                    w.byte_count = pick_count();
                    send_item(spims_pkg::KIND_START, w);
                    n += k + 1;
                end
                else if (p < 70)
                begin
                    // resend what the buffer already holds
                    w            = rand_word();
                    w.byte_count = 4'($urandom_range(1, 3));
                    send_item(spims_pkg::KIND_START, w);
                    n++;
                end
                else
                begin
                    send_noise();
                    n++;
                end
            end
        end
        calm = 1'b0;
    endtask

    // Stall the result side at random, except in quiet phases
    always @(posedge clk)
        m_axis_tready <= calm || ($urandom_range(99) >= 17);

    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Compare each accepted result word with the oldest expectation
    always @(posedge clk)
    begin : result_check
        pin_result_t          want;
        spims_pkg::out_word_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata;
            if (pin_words_q.size() == 0)
            begin
                $display("%0t: unexpected result word, expected none actual %h", $time,
                         m_axis_tdata);
                mismatches++;
            end
            else
            begin
                want = pin_words_q.pop_front();
                check_field("sclk", want.word.sclk, got.sclk);
                check_field("mosi", want.word.mosi, got.mosi);
                check_field("cs_active", want.word.cs_active, got.cs_active);
                check_field("cs_line", want.word.cs_line, got.cs_line);
                check_field("rx_byte", want.word.rx_byte, got.rx_byte);
                check_field("rx_valid", want.word.rx_valid, got.rx_valid);
                check_field("busy_res", want.word.busy_res, got.busy_res);
                check_field("error", want.word.error, got.error);
                check_field("rx_last", want.last, m_axis_tlast);
            end
        end
    end

    function automatic stim_row_t mk_row(logic [spims_pkg::IN_USER_W-1:0] kind,
                                         logic [7:0] txb, logic [3:0] cnt,
                                         logic [3:0] sel, logic miso,
                                         logic typed, logic err);
        stim_row_t r;
        r.kind  = kind;
        r.txb   = txb;
        r.cnt   = cnt;
        r.sel   = sel;
        r.miso  = miso;
        r.typed = typed;
        r.err   = err;
        return r;
    endfunction

    initial
    begin
        stim_row_t                  rows [$];
        spims_pkg::in_word_t        w;
        logic [spims_pkg::HP_W-1:0] hp;
        int                         p;

        // Idle checks right after reset, then a full buffer and the reject paths
        rows.push_back(mk_row(spims_pkg::KIND_TICK,  8'h00, 4'd0,  4'd0,  1'b0, 1'b1, 1'b0));
        rows.push_back(mk_row(KIND_UNUSED,           8'hFF, 4'd15, 4'd15, 1'b1, 1'b1, 1'b0));
        rows.push_back(mk_row(spims_pkg::KIND_PUSH,  8'h00, 4'd0,  4'd0,  1'b0, 1'b0, 1'b0));
        rows.push_back(mk_row(spims_pkg::KIND_PUSH,  8'hFF, 4'd15, 4'd15, 1'b1, 1'b0, 1'b0));
        rows.push_back(mk_row(spims_pkg::KIND_PUSH,  8'h80, 4'd0,  4'd0,  1'b0, 1'b0, 1'b0));
        rows.push_back(mk_row(spims_pkg::KIND_PUSH,  8'h01, 4'd0,  4'd0,  1'b0, 1'b0, 1'b0));
        rows.push_back(mk_row(spims_pkg::KIND_PUSH,  8'hA5, 4'd0,  4'd0,  1'b0, 1'b0, 1'b0));
        rows.push_back(mk_row(spims_pkg::KIND_PUSH,  8'h5A, 4'd0,  4'd0,  1'b0, 1'b0, 1'b0));
        rows.push_back(mk_row(spims_pkg::KIND_PUSH,  8'hC3, 4'd0,  4'd0,  1'b0, 1'b0, 1'b0));
        rows.push_back(mk_row(spims_pkg::KIND_PUSH,  8'h3C, 4'd0,  4'd0,  1'b0, 1'b0, 1'b0));
        // buffer full
        rows.push_back(mk_row(spims_pkg::KIND_PUSH,  8'h77, 4'd0,  4'd0,  1'b0, 1'b1, 1'b1));
        // counts above the buffer depth
        rows.push_back(mk_row(spims_pkg::KIND_START, 8'h00, 4'd15, 4'd15, 1'b0, 1'b1, 1'b1));
        rows.push_back(mk_row(spims_pkg::KIND_START, 8'h00, 4'd9,  4'd3,  1'b0, 1'b1, 1'b1));
        // zero count only rewinds the buffer, then the first entry is refilled
        rows.push_back(mk_row(spims_pkg::KIND_START, 8'h00, 4'd0,  4'd15, 1'b0, 1'b0, 1'b0));
        rows.push_back(mk_row(spims_pkg::KIND_PUSH,  8'h96, 4'd0,  4'd0,  1'b0, 1'b0, 1'b0));
        rows.push_back(mk_row(spims_pkg::KIND_START, 8'h00, 4'd1,  4'd15, 1'b0, 1'b0, 1'b0));
        // push and start while busy
        rows.push_back(mk_row(spims_pkg::KIND_PUSH,  8'h11, 4'd0,  4'd0,  1'b0, 1'b0, 1'b0));
        rows.push_back(mk_row(spims_pkg::KIND_START, 8'h00, 4'd2,  4'd1,  1'b0, 1'b0, 1'b0));
        rows.push_back(mk_row(spims_pkg::KIND_TICK,  8'h00, 4'd0,  4'd0,  1'b1, 1'b0, 1'b0));
        rows.push_back(mk_row(spims_pkg::KIND_TICK,  8'h00, 4'd0,  4'd0,  1'b0, 1'b0, 1'b0));
        rows.push_back(mk_row(spims_pkg::KIND_TICK,  8'h00, 4'd0,  4'd0,  1'b1, 1'b0, 1'b0));
        rows.push_back(mk_row(spims_pkg::KIND_TICK,  8'h00, 4'd0,  4'd0,  1'b1, 1'b0, 1'b0));
        rows.push_back(mk_row(spims_pkg::KIND_TICK,  8'h00, 4'd0,  4'd0,  1'b0, 1'b0, 1'b0));
        rows.push_back(mk_row(spims_pkg::KIND_TICK,  8'h00, 4'd0,  4'd0,  1'b1, 1'b0, 1'b0));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Walk the directed table with the reset configuration
        foreach (rows[i])
        begin
            w            = '0;
            w.tx_byte    = rows[i].txb;
            w.byte_count = rows[i].cnt;
            w.select_id  = rows[i].sel;
            w.miso       = rows[i].miso;
            send_item(rows[i].kind, w, rows[i].typed, rows[i].err);
        end

        // Fixed phases cover every mode and the half period extremes; the slow
        // phase is cut short so the next one shortens a half already under way
        run_phase(2'd1, 8'd0,   80,  1'b0);
        run_phase(2'd2, 8'd1,   120, 1'b0);
        run_phase(2'd3, 8'd2,   150, 1'b1);
        run_phase(2'd0, 8'd255, 400, 1'b0);
        run_phase(2'd3, 8'd1,   60,  1'b0);

        // Random phases until the word budget is spent
        while (items_sent < 880)
        begin
            p = $urandom_range(99);
            if (p < 60)
                hp = 8'd1;
            else if (p < 85)
                hp = 8'($urandom_range(2, 3));
            else if (p < 95)
                hp = 8'd0;
            else
                hp = 8'($urandom_range(4, 6));
            run_phase(2'($urandom_range(3)), hp, $urandom_range(40, 150), 1'b0);
        end

        drain();
        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("spi_master_shifter_tb OK");
        else
            $display("spi_master_shifter_tb NOT OK");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("spi_master_shifter_tb NOT OK");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/spims_pkg.sv
src/spi_master_shifter.sv
dv/spi_master_shifter_tb.sv
